/* sv/pitch_glide_ramp_unit_macros.svh */
// Assertion helpers shared by the pitch glide ramp RTL.
// Both expect signals named clock and reset in the module that uses them.
`ifndef PITCH_GLIDE_RAMP_UNIT_MACROS_SVH
`define PITCH_GLIDE_RAMP_UNIT_MACROS_SVH

// Same-cycle implication.
`define PGR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PGR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/pgr_pkg.sv */
`default_nettype none
package pgr_pkg;

   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_GLIDE = 2'd1;
   localparam logic [1:0] CMD_SET   = 2'd2;

   localparam int PITCH_W  = 16;
   localparam int DUR_W    = 16;
   localparam int STEP_W   = PITCH_W + 1;
   localparam int DIV_CNT_W = 4;

   localparam logic [DUR_W-1:0] DUR_MAX = {DUR_W{1'b1}};

   // controller -> datapath
   typedef struct packed {
      logic latch;     // capture request fields
      logic decide;    // tick / set / glide pre-checks
      logic mul;       // distance * duration product
      logic sat;       // retime saturation check, may start divide
      logic ret_done;  // retime quotient into duration
      logic setup;     // pick slow/fast mode, start divide
      logic commit;    // ramp parameters from quotient
      logic load_rsp;  // capture result
   } pgr_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic need_mul;
      logic need_setup;
      logic sat;
      logic div_busy;
   } pgr_sts_type;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_DECIDE = 8'b0000_0010,
      ST_MUL    = 8'b0000_0100,
      ST_SAT    = 8'b0000_1000,
      ST_RDIV   = 8'b0001_0000,
      ST_SETUP  = 8'b0010_0000,
      ST_DIV    = 8'b0100_0000,
      ST_RESULT = 8'b1000_0000
   } pgr_state_type;

endpackage
`default_nettype wire

/* sv/pgr_div.sv */
`default_nettype none
// Restoring divider, one quotient bit per cycle.
// Quotient of {rem_init, dividend} / divisor; rem_init must be below divisor.
module pgr_div
   import pgr_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [DUR_W-1:0]   rem_init,
   input  wire logic [DUR_W-1:0]   dividend,
   input  wire logic [DUR_W-1:0]   divisor,
   output logic                    busy,
   output logic [DUR_W-1:0]        quotient
);

   logic [DUR_W-1:0]     rem_ff, rem_in;
   logic [DUR_W-1:0]     dq_ff, dq_in;
   logic [DUR_W-1:0]     dsr_ff, dsr_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic [DUR_W:0]       rem_sh;
   logic [DUR_W:0]       rem_sub;
   logic                 ge;

   assign rem_sh  = {rem_ff, dq_ff[DUR_W-1]};
   assign ge      = rem_sh >= {1'b0, dsr_ff};
   assign rem_sub = rem_sh - {1'b0, dsr_ff};

   always_comb begin
      rem_in  = rem_ff;
      dq_in   = dq_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = rem_init;
         dq_in   = dividend;
         dsr_in  = divisor;
         cnt_in  = {DIV_CNT_W{1'b1}};
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? rem_sub[DUR_W-1:0] : rem_sh[DUR_W-1:0];
         dq_in  = {dq_ff[DUR_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = busy_ff;
   assign quotient = dq_ff;

endmodule
`default_nettype wire

/* sv/pgr_dp.sv */
`default_nettype none
module pgr_dp
   import pgr_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire pgr_cmd_type         cmd,
   output pgr_sts_type              sts,
   input  wire logic [1:0]          req_cmd,
   input  wire logic [PITCH_W-1:0]  req_target_pitch,
   input  wire logic [DUR_W-1:0]    req_tick_count,
   input  wire logic                req_retime,
   output logic [PITCH_W-1:0]       rsp_pitch,
   output logic                     rsp_ramp_active,
   output logic                     rsp_arrived
);

   // captured request
   logic [1:0]         op_ff;
   logic [PITCH_W-1:0] dest_ff;
   logic               retime_ff;
   logic [DUR_W-1:0]   dur_ff;

   // voice state
   logic [PITCH_W-1:0] cur_ff;
   logic [PITCH_W-1:0] tgt_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [DUR_W-1:0]   intv_ff;
   logic [DUR_W-1:0]   cd_ff;
   logic               slow_ff;
   logic               act_ff;
   logic               arr_ff;

   // glide setup work
   logic [2*DUR_W-1:0] prod_ff;
   logic [DUR_W-1:0]   pmag_ff;

   // result register
   logic [PITCH_W-1:0] rsp_pitch_ff;
   logic               rsp_act_ff;
   logic               rsp_arr_ff;

   logic [STEP_W-1:0]  change, prev, change_neg, prev_neg;
   logic [DUR_W-1:0]   mag, pmag;
   logic               jump_now, cur_nz, is_glide, slow_sel;

   logic [DUR_W-1:0]   cd_dec;
   logic [STEP_W:0]    np_wide, tgt_wide;
   logic               step_pos, step_neg, clamp;
   logic [PITCH_W-1:0] np;

   logic               div_start, div_busy;
   logic [DUR_W-1:0]   div_rem, div_dvd, div_dsr, quot;

   assign change     = {dest_ff[PITCH_W-1], dest_ff} - {cur_ff[PITCH_W-1], cur_ff};
   assign prev       = {dest_ff[PITCH_W-1], dest_ff} - {tgt_ff[PITCH_W-1], tgt_ff};
   assign change_neg = -change;
   assign prev_neg   = -prev;
   assign mag  = change[STEP_W-1] ? change_neg[DUR_W-1:0] : change[DUR_W-1:0];
   assign pmag = prev[STEP_W-1] ? prev_neg[DUR_W-1:0] : prev[DUR_W-1:0];

   assign is_glide = op_ff == CMD_GLIDE;
   assign cur_nz   = cur_ff != '0;
   assign jump_now = (dur_ff == '0) || (change == '0) ||
                     (act_ff && retime_ff && prev == '0);
   assign slow_sel = mag < dur_ff;

   assign sts.need_mul   = is_glide && cur_nz && !jump_now && act_ff && retime_ff;
   assign sts.need_setup = is_glide && cur_nz && !jump_now && !(act_ff && retime_ff);
   assign sts.sat        = prod_ff[2*DUR_W-1:DUR_W] >= pmag_ff;
   assign sts.div_busy   = div_busy;

   // tick step with clamp at target
   assign cd_dec   = cd_ff - {{(DUR_W-1){1'b0}}, cd_ff != '0};
   assign np_wide  = {{2{cur_ff[PITCH_W-1]}}, cur_ff} + {step_ff[STEP_W-1], step_ff};
   assign tgt_wide = {{2{tgt_ff[PITCH_W-1]}}, tgt_ff};
   assign step_pos = !step_ff[STEP_W-1] && step_ff != '0;
   assign step_neg = step_ff[STEP_W-1];
   assign clamp    = (step_pos && $signed(np_wide) > $signed(tgt_wide)) ||
                     (step_neg && $signed(np_wide) < $signed(tgt_wide));
   assign np       = clamp ? tgt_ff : np_wide[PITCH_W-1:0];

   // one divider serves the retime rescale and the mode setup
   assign div_start = (cmd.sat && !sts.sat) || cmd.setup;
   always_comb begin
      if (cmd.setup) begin
         div_rem = '0;
         div_dvd = slow_sel ? dur_ff : mag;
         div_dsr = slow_sel ? mag : dur_ff;
      end else begin
         div_rem = prod_ff[2*DUR_W-1:DUR_W];
         div_dvd = prod_ff[DUR_W-1:0];
         div_dsr = pmag_ff;
      end
   end

   pgr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .rem_init (div_rem),
      .dividend (div_dvd),
      .divisor  (div_dsr),
      .busy     (div_busy),
      .quotient (quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff  <= '0;
         tgt_ff  <= '0;
         step_ff <= '0;
         intv_ff <= '0;
         cd_ff   <= '0;
         slow_ff <= 1'b0;
         act_ff  <= 1'b0;
         arr_ff  <= 1'b0;
      end else begin
         if (cmd.decide) begin
            arr_ff <= 1'b0;
            case (op_ff)
               CMD_TICK: begin
                  if (act_ff) begin
                     if (cd_dec != '0) begin
                        cd_ff <= cd_dec;
                     end else begin
                        cur_ff <= np;
                        if (np == tgt_ff) begin
                           act_ff <= 1'b0;
                           arr_ff <= 1'b1;
                           cd_ff  <= '0;
                        end else begin
                           cd_ff <= slow_ff ? intv_ff : '0;
                        end
                     end
                  end
               end
               CMD_GLIDE: begin
                  if (cur_nz && jump_now) begin
                     cur_ff <= dest_ff;
                     act_ff <= 1'b0;
                  end
               end
               CMD_SET: begin
                  cur_ff <= dest_ff;
                  act_ff <= 1'b0;
               end
               default: begin
               end
            endcase
         end
         if (cmd.setup) begin
            slow_ff <= slow_sel;
         end
         if (cmd.commit) begin
            if (slow_ff) begin
               intv_ff <= quot;
               cd_ff   <= quot;
               step_ff <= change[STEP_W-1] ? {STEP_W{1'b1}} : STEP_W'(1);
            end else begin
               cd_ff   <= '0;
               step_ff <= change[STEP_W-1] ? -{1'b0, quot} : {1'b0, quot};
            end
            tgt_ff <= dest_ff;
            act_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff     <= req_cmd;
         dest_ff   <= req_target_pitch;
         retime_ff <= req_retime;
         dur_ff    <= req_tick_count;
      end else if (cmd.sat && sts.sat) begin
         dur_ff <= DUR_MAX;
      end else if (cmd.ret_done) begin
         dur_ff <= (quot == '0) ? DUR_W'(1) : quot;
      end
      if (cmd.mul) begin
         prod_ff <= mag * dur_ff;
         pmag_ff <= pmag;
      end
      if (cmd.load_rsp) begin
         rsp_pitch_ff <= cur_ff;
         rsp_act_ff   <= act_ff;
         rsp_arr_ff   <= arr_ff;
      end
   end

   assign rsp_pitch       = rsp_pitch_ff;
   assign rsp_ramp_active = rsp_act_ff;
   assign rsp_arrived     = rsp_arr_ff;

`include "pitch_glide_ramp_unit_macros.svh"

   `PGR_ASSERT_NOW(a_div_no_restart, div_start, !div_busy, "divider started while busy")
   `PGR_ASSERT_NOW(a_arrived_idle, arr_ff, !act_ff, "arrived with ramp still active")
   `PGR_ASSERT_NEXT(a_commit_active, cmd.commit, act_ff && step_ff != '0, "commit left no ramp")

endmodule
`default_nettype wire

/* sv/pgr_ctrl.sv */
`default_nettype none
module pgr_ctrl
   import pgr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output pgr_cmd_type      cmd,
   input  wire pgr_sts_type sts
);

   pgr_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          slot_free;

   assign req_ready = state_ff == ST_IDLE;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            if (sts.need_mul) begin
               state_in = ST_MUL;
            end else if (sts.need_setup) begin
               state_in = ST_SETUP;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SAT;
         end
         ST_SAT: begin
            cmd.sat  = 1'b1;
            state_in = sts.sat ? ST_SETUP : ST_RDIV;
         end
         ST_RDIV: begin
            if (!sts.div_busy) begin
               cmd.ret_done = 1'b1;
               state_in     = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (!sts.div_busy) begin
               cmd.commit = 1'b1;
               state_in   = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`include "pitch_glide_ramp_unit_macros.svh"

   `PGR_ASSERT_NEXT(a_accept_decide, req_valid && req_ready, state_ff == ST_DECIDE, "accept did not enter decide")
   `PGR_ASSERT_NEXT(a_result_shown, cmd.load_rsp, rsp_valid_ff && state_ff == ST_IDLE, "result not presented")
   `PGR_ASSERT_NOW(a_wait_busy, state_ff == ST_DIV && $past(state_ff) == ST_SETUP, sts.div_busy, "divider idle after setup")

endmodule
`default_nettype wire

/* sv/pitch_glide_ramp_unit.sv */
// Tick, set and unused commands pass from acceptance through the decide state to the result;
// a glide with an immediate jump or a silent voice likewise.
// A ramp glide adds the setup state and a serial divide; a retime of an active ramp first
// multiplies and checks saturation, then runs a second divide unless the duration saturates.
// One transaction at a time; the next is accepted the cycle after the result
// is registered. Reset (synchronous) clears pitch, target, step and ramp state to zero.
`default_nettype none
module pitch_glide_ramp_unit
   import pgr_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [1:0]          req_cmd,
   input  wire logic [PITCH_W-1:0]  req_target_pitch,
   input  wire logic [DUR_W-1:0]    req_tick_count,
   input  wire logic                req_retime,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [PITCH_W-1:0]       rsp_pitch,
   output logic                     rsp_ramp_active,
   output logic                     rsp_arrived
);

   pgr_cmd_type cmd;
   pgr_sts_type sts;

   pgr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   pgr_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_cmd          (req_cmd),
      .req_target_pitch (req_target_pitch),
      .req_tick_count   (req_tick_count),
      .req_retime       (req_retime),
      .rsp_pitch        (rsp_pitch),
      .rsp_ramp_active  (rsp_ramp_active),
      .rsp_arrived      (rsp_arrived)
   );

endmodule
`default_nettype wire

/* bench/pitch_glide_ramp_unit_tb.sv */
`timescale 1ns / 1ps
`default_nettype none
module pitch_glide_ramp_unit_tb;
   import pgr_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 1250;
   localparam int DRAIN_CYCLES = 60;

   class pitch_scoreboard;
      typedef struct {
         logic [PITCH_W-1:0] pitch;
         logic               ramp_active;
         logic               arrived;
      } voice_result_type;

      voice_result_type pending_pitches[$];

      // predicted voice state
      logic signed [PITCH_W-1:0] cur_pitch;
      logic signed [PITCH_W-1:0] tgt_pitch;
      logic signed [STEP_W-1:0]  step;
      logic [DUR_W-1:0]          interval;
      logic [DUR_W-1:0]          countdown;
      bit                        slow;
      bit                        ramping;

      int errors;
      int n_tick, n_glide, n_retime, n_set, n_unused, n_arrived, n_checked;

      function new();
         cur_pitch = '0;
         tgt_pitch = '0;
         step = '0;
         interval = '0;
         countdown = '0;
         slow = 0;
         ramping = 0;
      endfunction

      function void jump_to(logic signed [PITCH_W-1:0] p);
         cur_pitch = p;
         ramping = 0;
      endfunction

      function void glide_start(logic signed [PITCH_W-1:0] dest, logic [DUR_W-1:0] dur_in,
                                logic rt);
         int     change, prev, mag, dur;
         longint scaled;
         dur = int'(dur_in);
         if (cur_pitch == 0)
            return;
         change = int'(dest) - int'(cur_pitch);
         if (dur == 0 || change == 0) begin
            jump_to(dest);
            return;
         end
         if (ramping && rt) begin
            prev = int'(dest) - int'(tgt_pitch);
            if (prev == 0) begin
               jump_to(dest);
               return;
            end
            scaled = longint'(change) * longint'(dur) / longint'(prev);
            if (scaled < 0)
               scaled = -scaled;
            if (scaled == 0)
               scaled = 1;
            if (scaled > longint'(DUR_MAX))
               scaled = longint'(DUR_MAX);
            dur = int'(scaled);
         end
         mag = (change < 0) ? -change : change;
         if (mag < dur) begin
            interval = DUR_W'(dur / mag);
            slow = 1;
            countdown = interval;
            step = STEP_W'((change < 0) ? -1 : 1);
         end else begin
            step = STEP_W'(change / dur);
            slow = 0;
            countdown = '0;
         end
         tgt_pitch = dest;
         ramping = 1;
      endfunction

      // returns 1 when this tick lands on the target
      function bit glide_tick();
         int np;
         if (!ramping)
            return 0;
         if (countdown != 0)
            countdown--;
         if (countdown != 0)
            return 0;
         np = int'(cur_pitch) + int'(step);
         if ((step > 0 && np > int'(tgt_pitch)) || (step < 0 && np < int'(tgt_pitch)))
            np = int'(tgt_pitch);
         if (np > 32767)
            np -= 65536;
         if (np < -32768)
            np += 65536;
         cur_pitch = np[PITCH_W-1:0];
         if (np == int'(tgt_pitch)) begin
            ramping = 0;
            return 1;
         end
         if (slow)
            countdown = interval;
         return 0;
      endfunction

      function void note_request(logic [1:0] cmd, logic [PITCH_W-1:0] tp,
                                 logic [DUR_W-1:0] ticks, logic rt);
         voice_result_type e;
         e.arrived = 0;
         case (cmd)
            CMD_TICK: begin
               e.arrived = glide_tick();
               n_tick++;
               if (e.arrived)
                  n_arrived++;
            end
            CMD_GLIDE: begin
               glide_start(tp, ticks, rt);
               n_glide++;
               if (rt)
                  n_retime++;
            end
            CMD_SET: begin
               jump_to(tp);
               n_set++;
            end
            default: n_unused++;
         endcase
         e.pitch = cur_pitch;
         e.ramp_active = ramping;
         pending_pitches.push_back(e);
      endfunction

      function void check_result(logic [PITCH_W-1:0] pitch, logic ra, logic arr);
         voice_result_type e;
         if (pending_pitches.size() == 0) begin
            $error("response with none expected: pitch %0d ramp_active %0b arrived %0b",
                   $signed(pitch), ra, arr);
            errors++;
            return;
         end
         e = pending_pitches.pop_front();
         n_checked++;
         if (pitch !== e.pitch) begin
            $error("pitch: expected %0d, actual %0d", $signed(e.pitch), $signed(pitch));
            errors++;
         end
         if (ra !== e.ramp_active) begin
            $error("ramp_active: expected %0b, actual %0b", e.ramp_active, ra);
            errors++;
         end
         if (arr !== e.arrived) begin
            $error("arrived: expected %0b, actual %0b", e.arrived, arr);
            errors++;
         end
      endfunction

      function int pending();
         return pending_pitches.size();
      endfunction
   endclass

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_cmd = CMD_TICK;
   logic [PITCH_W-1:0] req_target_pitch = '0;
   logic [DUR_W-1:0]   req_tick_count = '0;
   logic               req_retime = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [PITCH_W-1:0] rsp_pitch;
   logic               rsp_ramp_active;
   logic               rsp_arrived;

   pitch_scoreboard sb;
   int req_calm = 0;
   int rsp_calm = 0;

   pitch_glide_ramp_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_target_pitch (req_target_pitch),
      .req_tick_count   (req_tick_count),
      .req_retime       (req_retime),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pitch        (rsp_pitch),
      .rsp_ramp_active  (rsp_ramp_active),
      .rsp_arrived      (rsp_arrived)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // random idle gap, with occasional stretches of back-to-back traffic
   function automatic int draw_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0)
         calm = $urandom_range(10, 40);
      return $urandom_range(0, 8);
   endfunction

   task automatic send_request(input logic [1:0] cmd, input logic [PITCH_W-1:0] tp,
                               input logic [DUR_W-1:0] ticks, input logic rt);
      int gap;
      gap = draw_gap(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_cmd          <= cmd;
      req_target_pitch <= tp;
      req_tick_count   <= ticks;
      req_retime       <= rt;
      do @(posedge clock); while (!req_ready);
      sb.note_request(cmd, tp, ticks, rt);
   endtask

   // result side
   initial begin
      int gap;
      wait (!reset);
      @(posedge clock);
      forever begin
         gap = draw_gap(rsp_calm);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_result(rsp_pitch, rsp_ramp_active, rsp_arrived);
      end
   end

   initial begin
      #(20_000_000);
      $display("** pitch_glide_ramp_unit: FAILED **");
      $finish;
   end

   initial begin
      int pick, nticks, span, d_int, r;
      logic [PITCH_W-1:0] dest;
      logic [DUR_W-1:0]   dur;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed
      send_request(CMD_TICK, 16'sd0, 16'd0, 1'b0);            // idle tick
      send_request(CMD_UNUSED, 16'h7FFF, 16'hFFFF, 1'b1);
      send_request(CMD_GLIDE, 16'sd500, 16'd10, 1'b0);        // silent voice
      send_request(CMD_SET, 16'h8000, 16'd0, 1'b0);
      send_request(CMD_GLIDE, 16'h7FFF, 16'd1, 1'b0);         // full-range single step
      send_request(CMD_TICK, 16'sd0, 16'd0, 1'b0);
      send_request(CMD_GLIDE, 16'h8000, 16'd0, 1'b0);         // zero duration jump
      send_request(CMD_GLIDE, 16'h8000, 16'd5, 1'b0);         // no change jump
      send_request(CMD_SET, 16'sd1000, 16'd0, 1'b0);
      send_request(CMD_GLIDE, 16'sd1003, 16'd7, 1'b1);        // retime with no ramp, slow
      send_request(CMD_TICK, 16'sd0, 16'd0, 1'b0);
      send_request(CMD_TICK, 16'sd0, 16'd0, 1'b0);
      send_request(CMD_GLIDE, 16'sd1003, 16'd9, 1'b1);        // retime, same target
      send_request(CMD_SET, 16'sd5, 16'd0, 1'b0);
      send_request(CMD_GLIDE, 16'sd100, 16'd10, 1'b0);
      send_request(CMD_TICK, 16'sd0, 16'd0, 1'b0);
      send_request(CMD_GLIDE, 16'sd99, 16'hFFFF, 1'b1);       // retime saturates
      send_request(CMD_GLIDE, 16'sd15, 16'd1, 1'b1);          // retime rounds to zero
      send_request(CMD_TICK, 16'sd0, 16'd0, 1'b0);
      send_request(CMD_GLIDE, 16'h8000, 16'hFFFF, 1'b0);
      send_request(CMD_TICK, 16'sd0, 16'd0, 1'b0);
      send_request(CMD_SET, 16'h7FFF, 16'd0, 1'b0);
      send_request(CMD_SET, 16'sd0, 16'd0, 1'b0);

      // random: mostly glides followed by ticks, some sets and noise
      r = 0;
      while (r < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 10 || (sb.cur_pitch == 0 && pick < 70)) begin
            dest = (pick < 2) ? 16'd0 : 16'($urandom);
            send_request(CMD_SET, dest, 16'($urandom), 1'($urandom));
            r++;
         end else if (pick < 85) begin
            if ($urandom_range(0, 3) == 0)
               dest = 16'($urandom);
            else begin
               d_int = int'(sb.cur_pitch) + int'($urandom_range(0, 400)) - 200;
               dest = d_int[PITCH_W-1:0];
            end
            case ($urandom_range(0, 19))
               0:       dur = '0;
               1:       dur = 16'($urandom);
               default: dur = 16'($urandom_range(1, 48));
            endcase
            send_request(CMD_GLIDE, dest, dur, 1'($urandom));
            r++;
            span = (dur > 48) ? 48 : int'(dur);
            nticks = $urandom_range(0, 2 * span + 4);
            repeat (nticks) begin
               if ($urandom_range(0, 29) == 0) begin
                  d_int = int'(sb.tgt_pitch) + int'($urandom_range(0, 200)) - 100;
                  send_request(CMD_GLIDE, d_int[PITCH_W-1:0],
                               16'($urandom_range(1, 64)), 1'b1);
               end else
                  send_request(CMD_TICK, 16'($urandom), 16'($urandom), 1'($urandom));
               r++;
            end
         end else begin
            send_request(2'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
            r++;
         end
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d results: %0d ticks (%0d arrivals), %0d glides (%0d with retime),",
               sb.n_checked, sb.n_tick, sb.n_arrived, sb.n_glide, sb.n_retime);
      $display("%0d direct sets and %0d unused commands; %0d mismatches.",
               sb.n_set, sb.n_unused, sb.errors);
      if (sb.errors == 0)
         $display("** pitch_glide_ramp_unit: PASSED **");
      else
         $display("** pitch_glide_ramp_unit: FAILED **");
      $finish;
   end

endmodule
`default_nettype wire
